/* hdl/ccbs_pkg.sv */
package ccbs_pkg;

  localparam int ELEM_W = 32;
  localparam int CAPACITY_DEF = 64;

endpackage

/* hdl/ccbs_ram.sv */
module ccbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hdl/ccbs_sequencer.sv */
module ccbs_sequencer #(
  parameter int CAPACITY = ccbs_pkg::CAPACITY_DEF,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ccbs_pkg::ELEM_W-1:0] element_value,
  input  logic                              carries_element,
  input  logic                              end_of_load,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ccbs_pkg::ELEM_W-1:0] sorted_value,
  output logic                              is_last,
  output logic                              set_empty,
  output logic                              overflowed,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [ccbs_pkg::ELEM_W-1:0]       ram_wdata,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_raddr,
  input  logic [ccbs_pkg::ELEM_W-1:0]       ram_rdata
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b0000_0001,
    S_PASS_START = 8'b0000_0010,
    S_LOAD_HOLD  = 8'b0000_0100,
    S_STEP       = 8'b0000_1000,
    S_PASS_END   = 8'b0001_0000,
    S_EMIT_RD    = 8'b0010_0000,
    S_EMIT_WAIT  = 8'b0100_0000,
    S_EMIT_HOLD  = 8'b1000_0000
  } state_t;

  state_t                      state;
  logic [CW-1:0]               count;
  logic                        ovf;
  logic [AW-1:0]               k;
  logic [AW-1:0]               last;
  logic [AW-1:0]               idx;
  logic [ccbs_pkg::ELEM_W-1:0] hold;

  logic          accept;
  logic          has_room;
  logic [CW-1:0] count_next;
  logic          ovf_next;
  logic          swap;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign has_room = (count < CW'(CAPACITY));

  always_comb begin
    count_next = count;
    ovf_next   = ovf;
    if (carries_element) begin
      if (has_room) begin
        count_next = count + CW'(1);
      end else begin
        ovf_next = 1'b1;
      end
    end
  end

  // carried element stays in hold while it is the larger one
  assign swap = ($signed(hold) > $signed(ram_rdata));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = k;
    ram_wdata = hold;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_IDLE: begin
        ram_we    = accept && carries_element && has_room;
        ram_waddr = count[AW-1:0];
        ram_wdata = element_value;
      end
      S_PASS_START: begin
        ram_re = 1'b1;
      end
      S_LOAD_HOLD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(1);
      end
      S_STEP: begin
        ram_re    = 1'b1;
        ram_raddr = k + AW'(2);
        ram_we    = 1'b1;
        ram_waddr = k;
        ram_wdata = swap ? ram_rdata : hold;
      end
      S_PASS_END: begin
        ram_we    = 1'b1;
        ram_waddr = last;
        ram_wdata = hold;
      end
      S_EMIT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx;
      end
      S_EMIT_WAIT, S_EMIT_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ovf       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_next;
            ovf   <= ovf_next;
            if (end_of_load) begin
              if (count_next == '0) begin
                sorted_value <= '0;
                is_last      <= 1'b1;
                set_empty    <= 1'b1;
                overflowed   <= ovf_next;
                out_valid    <= 1'b1;
                state        <= S_EMIT_HOLD;
              end else if (count_next == CW'(1)) begin
                idx   <= '0;
                state <= S_EMIT_RD;
              end else begin
                last  <= AW'(count_next - CW'(1));
                state <= S_PASS_START;
              end
            end
          end
        end
        S_PASS_START: begin
          state <= S_LOAD_HOLD;
        end
        S_LOAD_HOLD: begin
          hold  <= ram_rdata;
          k     <= '0;
          state <= S_STEP;
        end
        S_STEP: begin
          if (!swap) begin
            hold <= ram_rdata;
          end
          k <= k + AW'(1);
          if (k + AW'(1) == last) begin
            state <= S_PASS_END;
          end
        end
        S_PASS_END: begin
          last <= last - AW'(1);
          if (last == AW'(1)) begin
            idx   <= '0;
            state <= S_EMIT_RD;
          end else begin
            state <= S_PASS_START;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          sorted_value <= ram_rdata;
          is_last      <= (CW'(idx) == count - CW'(1));
          set_empty    <= 1'b0;
          overflowed   <= ovf;
          out_valid    <= 1'b1;
          state        <= S_EMIT_HOLD;
        end
        S_EMIT_HOLD: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            if (is_last) begin
              count <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              idx   <= idx + AW'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* hdl/concat_and_bubble_sort_unit.sv */
// load: one input transaction per cycle while idle; stall stays high from the ending transaction on
// sort of n elements: one compare-swap per cycle on the store ram
// emit: per result a ram read, an output register and a handshake, plus output stall
// from end: sort, read, output register; empty set answers in the cycle after the end
// throughput bound by the single read and single write port of the element store
// reset clears count, overflow flag and control; store contents are undefined until written
module concat_and_bubble_sort_unit #(
  parameter int CAPACITY = ccbs_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [ccbs_pkg::ELEM_W-1:0] element_value,
  input  logic                              carries_element,
  input  logic                              end_of_load,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [ccbs_pkg::ELEM_W-1:0] sorted_value,
  output logic                              is_last,
  output logic                              set_empty,
  output logic                              overflowed
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [ccbs_pkg::ELEM_W-1:0] ram_wdata;
  logic                        ram_re;
  logic [AW-1:0]               ram_raddr;
  logic [ccbs_pkg::ELEM_W-1:0] ram_rdata;

  ccbs_sequencer #(
    .CAPACITY(CAPACITY)
  ) u_seq (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .element_value   (element_value),
    .carries_element (carries_element),
    .end_of_load     (end_of_load),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .sorted_value    (sorted_value),
    .is_last         (is_last),
    .set_empty       (set_empty),
    .overflowed      (overflowed),
    .ram_we          (ram_we),
    .ram_waddr       (ram_waddr),
    .ram_wdata       (ram_wdata),
    .ram_re          (ram_re),
    .ram_raddr       (ram_raddr),
    .ram_rdata       (ram_rdata)
  );

  ccbs_ram #(
    .WIDTH(ccbs_pkg::ELEM_W),
    .DEPTH(CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* verif/ccbs_checker.sv */
`timescale 1ns / 1ps

module ccbs_checker #(
  parameter int CAPACITY = ccbs_pkg::CAPACITY_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic signed [ccbs_pkg::ELEM_W-1:0] element_value,
  input  logic                               carries_element,
  input  logic                               end_of_load,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic signed [ccbs_pkg::ELEM_W-1:0] sorted_value,
  input  logic                               is_last,
  input  logic                               set_empty,
  input  logic                               overflowed,
  output int                                 fail_count,
  output int                                 outstanding
);
  import ccbs_pkg::*;

  typedef struct packed {
    logic signed [ELEM_W-1:0] value;
    logic                     last;
    logic                     empty;
    logic                     dropped;
  } sorted_result_t;

  logic signed [ELEM_W-1:0] loaded [CAPACITY];
  int                       load_count;
  logic                     load_dropped;
  sorted_result_t           pending_sorted [$];
  sorted_result_t           want;
  logic signed [ELEM_W-1:0] swap_tmp;
  int                       pass_i;
  int                       k;

  initial begin
    fail_count = 0;
    outstanding = 0;
    load_count = 0;
    load_dropped = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      load_count = 0;
      load_dropped = 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (carries_element) begin
          if (load_count < CAPACITY) begin
            loaded[load_count] = element_value;
            load_count++;
          end else begin
            load_dropped = 1'b1;
          end
        end
        if (end_of_load) begin
          if (load_count == 0) begin
            want.value = '0;
            want.last = 1'b1;
            want.empty = 1'b1;
            want.dropped = load_dropped;
            pending_sorted.push_back(want);
          end else begin
            // strict compare keeps equal elements in place
            for (pass_i = 0; pass_i + 1 < load_count; pass_i++) begin
              for (k = 0; k + 1 < load_count - pass_i; k++) begin
                if (loaded[k] > loaded[k+1]) begin
                  swap_tmp = loaded[k];
                  loaded[k] = loaded[k+1];
                  loaded[k+1] = swap_tmp;
                end
              end
            end
            for (k = 0; k < load_count; k++) begin
              want.value = loaded[k];
              want.last = (k + 1 == load_count);
              want.empty = 1'b0;
              want.dropped = load_dropped;
              pending_sorted.push_back(want);
            end
          end
          load_count = 0;
          load_dropped = 1'b0;
        end
      end

      if (out_valid && !out_stall) begin
        if (pending_sorted.size() == 0) begin
          $error("unexpected result transaction: sorted_value %0d", sorted_value);
          fail_count++;
        end else begin
          want = pending_sorted.pop_front();
          if (sorted_value !== want.value) begin
            $error("sorted_value: expected %0d, got %0d", $signed(want.value), sorted_value);
            fail_count++;
          end
          if (is_last !== want.last) begin
            $error("is_last: expected %0d, got %0d", want.last, is_last);
            fail_count++;
          end
          if (set_empty !== want.empty) begin
            $error("set_empty: expected %0d, got %0d", want.empty, set_empty);
            fail_count++;
          end
          if (overflowed !== want.dropped) begin
            $error("overflowed: expected %0d, got %0d", want.dropped, overflowed);
            fail_count++;
          end
        end
      end
    end
    outstanding <= pending_sorted.size();
  end

endmodule

/* verif/tb_concat_and_bubble_sort_unit.sv */
`timescale 1ns / 1ps

module tb_concat_and_bubble_sort_unit;
  import ccbs_pkg::*;

  localparam int CAP          = CAPACITY_DEF;
  localparam int RANDOM_ITEMS = 160;
  localparam int STALL_LIMIT  = 20000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_GAP      = 13;

  localparam logic signed [ELEM_W-1:0] ELEM_MIN = 32'sh8000_0000;
  localparam logic signed [ELEM_W-1:0] ELEM_MAX = 32'sh7fff_ffff;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] element_value = '0;
  logic                     carries_element = 1'b0;
  logic                     end_of_load = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b1;
  logic signed [ELEM_W-1:0] sorted_value;
  logic                     is_last;
  logic                     set_empty;
  logic                     overflowed;

  int fail_count;
  int outstanding;
  int items_sent = 0;
  int idle_cycles = 0;
  int run_idx;
  int list_len;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  int rx_wait;

  always #10 clk = ~clk;

  concat_and_bubble_sort_unit #(
    .CAPACITY(CAP)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .element_value(element_value),
    .carries_element(carries_element),
    .end_of_load(end_of_load),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sorted_value(sorted_value),
    .is_last(is_last),
    .set_empty(set_empty),
    .overflowed(overflowed)
  );

  ccbs_checker #(
    .CAPACITY(CAP)
  ) u_checker (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .element_value(element_value),
    .carries_element(carries_element),
    .end_of_load(end_of_load),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sorted_value(sorted_value),
    .is_last(is_last),
    .set_empty(set_empty),
    .overflowed(overflowed),
    .fail_count(fail_count),
    .outstanding(outstanding)
  );

  // mix of extremes, near-zero values (duplicates) and full-range words
  function automatic logic signed [ELEM_W-1:0] rand_elem();
    case ($urandom_range(0, 5))
      0: rand_elem = ELEM_MIN;
      1: rand_elem = ELEM_MAX;
      2: rand_elem = $signed($urandom_range(0, 8)) - 4;
      default: rand_elem = $urandom;
    endcase
  endfunction

  task automatic send_item(input logic signed [ELEM_W-1:0] value, input logic carries,
                           input logic ending);
    int gap;
    if ($urandom_range(0, 15) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    element_value <= value;
    carries_element <= carries;
    end_of_load <= ending;
    do @(posedge clk); while (!(in_valid && !in_stall));
    items_sent++;
  endtask

  // hold off the sender until every predicted result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_list(input int n_elems);
    bit last_on_end;
    int k;
    last_on_end = (n_elems > 0) && ($urandom_range(0, 1) == 1);
    for (k = 0; k < n_elems - int'(last_on_end); k++) begin
      if ($urandom_range(0, 7) == 0) send_item($urandom, 1'b0, 1'b0);
      send_item(rand_elem(), 1'b1, 1'b0);
    end
    if (last_on_end) send_item(rand_elem(), 1'b1, 1'b1);
    else send_item($urandom, 1'b0, 1'b1);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty set
    send_item($urandom, 1'b0, 1'b1);
    // single element on the ending transaction
    send_item(ELEM_MAX, 1'b1, 1'b1);
    // extremes, last one stored on the ending transaction
    send_item(ELEM_MIN, 1'b1, 1'b0);
    send_item(ELEM_MAX, 1'b1, 1'b0);
    send_item(32'sd0, 1'b1, 1'b0);
    send_item(-32'sd1, 1'b1, 1'b0);
    send_item(32'sd1, 1'b1, 1'b1);
    // duplicates, an idle transaction inside the load, end without element
    send_item(32'sd5, 1'b1, 1'b0);
    send_item($urandom, 1'b0, 1'b0);
    send_item(32'sd5, 1'b1, 1'b0);
    send_item(-32'sd5, 1'b1, 1'b0);
    send_item($urandom, 1'b0, 1'b1);
    // descending input
    send_item(32'sd100, 1'b1, 1'b0);
    send_item(32'sd50, 1'b1, 1'b0);
    send_item(32'sd0, 1'b1, 1'b0);
    send_item(-32'sd50, 1'b1, 1'b0);
    send_item(-32'sd100, 1'b1, 1'b0);
    send_item(ELEM_MIN, 1'b1, 1'b1);
    // already sorted input
    send_item(32'sd1, 1'b1, 1'b0);
    send_item(32'sd2, 1'b1, 1'b0);
    send_item(32'sd3, 1'b1, 1'b1);
    wait_drained();

    run_idx = 0;
    while (items_sent < RANDOM_ITEMS) begin
      // one run fills the store and pushes past it
      if (run_idx == 2) list_len = CAP + $urandom_range(1, 3);
      else if ($urandom_range(0, 5) == 0) list_len = $urandom_range(9, 24);
      else list_len = $urandom_range(0, 8);
      send_list(list_len);
      if ($urandom_range(0, 4) == 0) wait_drained();
      run_idx++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  // result side: random hold-off before each transaction, with stall-free stretches
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      if (rx_wait > 0) begin
        out_stall <= 1'b1;
        repeat (rx_wait) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

endmodule
